### rtl/core/tea_pkg.sv
// shared types, constants and round function for the tea cipher unit
package tea_pkg;

    localparam int WORD_W = 32;
    localparam int KEY_IDX_W = 2;

    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

    // command codes
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // configuration register indexes
    localparam logic [KEY_IDX_W-1:0] KEY_WORD_0_IDX = 2'd0;
    localparam logic [KEY_IDX_W-1:0] KEY_WORD_1_IDX = 2'd1;
    localparam logic [KEY_IDX_W-1:0] KEY_WORD_2_IDX = 2'd2;
    localparam logic [KEY_IDX_W-1:0] KEY_WORD_3_IDX = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] k0;
        logic [WORD_W-1:0] k1;
        logic [WORD_W-1:0] k2;
        logic [WORD_W-1:0] k3;
    } key_t;

    // one pipeline beat: valid bit travels with the data
    typedef struct packed {
        logic              valid;
        logic              cmd;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
    } beat_t;

    function automatic logic [WORD_W-1:0] tea_mix(
        input logic [WORD_W-1:0] v,
        input logic [WORD_W-1:0] sum,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb
    );
        return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
    endfunction

    // delta times n, mod 2^32; used for elaboration-time constants only
    function automatic logic [WORD_W-1:0] round_sum(input int n);
        logic [63:0] prod;
        prod = 64'(TEA_DELTA) * 64'(n);
        return prod[WORD_W-1:0];
    endfunction

endpackage

### rtl/core/tea_key_regs.sv
// key word registers written through the configuration port
module tea_key_regs
    import tea_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [KEY_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    output key_t                 key
);

    key_t key_reg;
    key_t key_next;

    always_comb
    begin
        key_next = key_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                KEY_WORD_0_IDX: key_next.k0 = cfg_data;
                KEY_WORD_1_IDX: key_next.k1 = cfg_data;
                KEY_WORD_2_IDX: key_next.k2 = cfg_data;
                KEY_WORD_3_IDX: key_next.k3 = cfg_data;
                default:        key_next = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    assign key = key_reg;

endmodule

### rtl/core/tea_half_round.sv
// one registered half-round stage, shared by encrypt and decrypt
module tea_half_round
    import tea_pkg::*;
#(
    parameter logic [31:0] ENC_SUM    = 32'h9E37_79B9,
    parameter logic [31:0] DEC_SUM    = 32'h9E37_79B9,
    parameter bit          FIRST_HALF = 1'b1
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  key_t  key,
    input  beat_t beat_in,
    output beat_t beat_out
);

    logic              update_y;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] src;
    logic [WORD_W-1:0] dst;
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] dst_new;
    beat_t             beat_next;
    logic              valid_reg;
    logic              cmd_reg;
    logic [WORD_W-1:0] y_reg;
    logic [WORD_W-1:0] z_reg;

    // encrypt: first half updates y, second z; decrypt the other way round
    assign update_y = ((beat_in.cmd == CMD_ENCRYPT) == FIRST_HALF);
    assign sum      = (beat_in.cmd == CMD_ENCRYPT) ? ENC_SUM : DEC_SUM;
    assign src      = update_y ? beat_in.z : beat_in.y;
    assign dst      = update_y ? beat_in.y : beat_in.z;
    assign mix      = update_y ? tea_mix(src, sum, key.k0, key.k1)
                               : tea_mix(src, sum, key.k2, key.k3);
    assign dst_new  = (beat_in.cmd == CMD_ENCRYPT) ? (dst + mix) : (dst - mix);

    always_comb
    begin
        beat_next       = beat_in;
        beat_next.valid = beat_in.valid;
        if (update_y)
        begin
            beat_next.y = dst_new;
        end
        else
        begin
            beat_next.z = dst_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= beat_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= beat_next.cmd;
        y_reg   <= beat_next.y;
        z_reg   <= beat_next.z;
    end

    assign beat_out = '{valid: valid_reg, cmd: cmd_reg, y: y_reg, z: z_reg};

`ifndef SYNTHESIS
    a_valid_travels: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (valid_reg == $past(beat_in.valid)))
        else $error("valid bit lost or invented in half-round stage");

    a_cmd_travels: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && valid_reg |-> (cmd_reg == $past(beat_in.cmd)))
        else $error("command changed inside half-round stage");

    a_other_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && valid_reg |->
            ($past(update_y) ? (z_reg == $past(beat_in.z))
                             : (y_reg == $past(beat_in.y))))
        else $error("half-round stage altered the word it should pass");
`endif

endmodule

### rtl/core/tea_block_cipher_unit.sv
// tea block cipher unit: fully unrolled pipeline, one half-round per stage
// the start beat passes through every registered half-round stage in turn before the done strobe
// throughput: one block per cycle; busy stays low, start is taken every cycle
// the depth is set by the half-round chain, one add-xor-add mix per register stage
// reset: rst_n clears key words to zero and empties the pipeline valid bits
// the receiver cannot stall: each result shows for exactly one cycle with done
module tea_block_cipher_unit
    import tea_pkg::*;
#(
    parameter int ROUNDS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // command side
    input  logic                 start,
    output logic                 busy,
    input  logic                 command,
    input  logic [WORD_W-1:0]    block_low,
    input  logic [WORD_W-1:0]    block_high,
    // result side
    output logic                 done,
    output logic [WORD_W-1:0]    out_low,
    output logic [WORD_W-1:0]    out_high,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [KEY_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    localparam int STAGES = 2 * ROUNDS;

    key_t  key;
    beat_t pipe [0:STAGES];

    // key words must only change while the pipeline is empty (not enforced here); every stage reads them live
    tea_key_regs u_key_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key       (key)
    );

    // a new beat enters on every start; nothing upstream ever has to wait
    assign busy    = 1'b0;
    assign pipe[0] = '{valid: start & ~busy, cmd: command, y: block_low, z: block_high};

    // stage 2r and 2r+1 form round r; encrypt sum is delta*(r+1),
    // decrypt walks sum down from delta*ROUNDS
    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        localparam int          RND     = s / 2;
        localparam logic [31:0] ENC_SUM = round_sum(RND + 1);
        localparam logic [31:0] DEC_SUM = round_sum(ROUNDS - RND);

        tea_half_round #(
            .ENC_SUM    (ENC_SUM),
            .DEC_SUM    (DEC_SUM),
            .FIRST_HALF ((s % 2) == 0)
        ) u_half_round (
            .clk      (clk),
            .rst_n    (rst_n),
            .key      (key),
            .beat_in  (pipe[s]),
            .beat_out (pipe[s+1])
        );
    end

    // last stage register drives the result ports directly
    assign done     = pipe[STAGES].valid;
    assign out_low  = pipe[STAGES].y;
    assign out_high = pipe[STAGES].z;

endmodule
